// ----- hw/rtl/rme_pkg.sv -----
package rme_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int PI_Q13            = 25736;
    localparam int HALF_PI_Q13       = 12868;
    localparam int QUARTER_PI_Q30    = 843314857;
    localparam int CX_W              = 50;
    localparam int CZ_W              = 35;
    localparam int SQRT_STEPS        = 16;

    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) scaled by 2^30, from the alternating series (the pi/4 constant for i = 0)
    function automatic logic [31:0] atan_q30(int unsigned i);
        logic signed [63:0] sum;
        logic        [63:0] term;
        logic signed [63:0] rnd;
        int unsigned        e;
        sum = '0;
        if (i == 0) begin
            return 32'(QUARTER_PI_Q30);
        end
        for (int unsigned k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
                term = udiv64(64'd1 << (60 - e), 64'(2 * k + 1));
                if (k[0]) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
        end
        rnd = (sum + (64'sd1 <<< 29)) >>> 30;
        return rnd[31:0];
    endfunction

endpackage

// ----- hw/rtl/rme_cordic.sv -----
module rme_cordic #(
    parameter int STAGES = rme_pkg::CORDIC_STAGES_DEF,
    parameter int LIMIT  = rme_pkg::PI_Q13
) (
    input  logic                 i_clk,
    input  logic [STAGES+1:0]    i_en,
    input  logic signed [16:0]   i_y,
    input  logic signed [16:0]   i_x,
    output logic signed [15:0]   o_angle
);
    import rme_pkg::*;

    localparam logic signed [CZ_W-1:0] HALF_PI_Z = CZ_W'(2 * 64'(QUARTER_PI_Q30));
    localparam logic signed [CZ_W-1:0] LIM_Z     = CZ_W'(LIMIT);

    logic signed [CX_W-1:0] r_x [0:STAGES];
    logic signed [CX_W-1:0] r_y [0:STAGES];
    logic signed [CZ_W-1:0] r_z [0:STAGES];
    logic                   r_zero [0:STAGES];
    logic signed [15:0]     r_ang;

    logic signed [CX_W-1:0] w_xs;
    logic signed [CX_W-1:0] w_ys;
    logic signed [CX_W-1:0] n_x0;
    logic signed [CX_W-1:0] n_y0;
    logic signed [CZ_W-1:0] n_z0;
    logic signed [CZ_W-1:0] w_r;
    logic signed [15:0]     n_ang;

    assign w_xs = {{(CX_W-47){i_x[16]}}, i_x, 30'd0};
    assign w_ys = {{(CX_W-47){i_y[16]}}, i_y, 30'd0};

    // quadrant fold
    always_comb begin
        n_x0 = w_xs;
        n_y0 = w_ys;
        n_z0 = '0;
        if (w_xs < 0) begin
            if (w_ys >= 0) begin
                n_x0 = w_ys;
                n_y0 = -w_xs;
                n_z0 = HALF_PI_Z;
            end else begin
                n_x0 = -w_ys;
                n_y0 = w_xs;
                n_z0 = -HALF_PI_Z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [CZ_W-1:0] ANG = $signed({{(CZ_W-32){1'b0}}, atan_q30(i)});
        logic signed [CX_W-1:0] w_dx;
        logic signed [CX_W-1:0] w_dy;
        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en[i+1]) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + ANG;
                end else begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - ANG;
                end
            end
        end
    end

    assign w_r = (r_z[STAGES] + (CZ_W'(1) <<< 16)) >>> 17;

    always_comb begin
        if (r_zero[STAGES]) begin
            n_ang = '0;
        end else if (w_r > LIM_Z) begin
            n_ang = LIM_Z[15:0];
        end else if (w_r < -LIM_Z) begin
            n_ang = 16'(-LIM_Z);
        end else begin
            n_ang = w_r[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[STAGES+1]) begin
            r_ang <= n_ang;
        end
    end

    assign o_angle = r_ang;

endmodule

// ----- hw/rtl/rotation_matrix_to_euler.sv -----
// channel   dir  fields
// s_axis    in   tdata: r11, r21, r31, r32, r33 (16 bits each, Q1.15)
// m_axis    out  tdata: angle_pitch(15), angle_yaw(16), angle_roll(16), pad; tuser: degenerate
//
// one word accepted per cycle unless a stalled output fills the pipeline; the stages are
// two square/sum stages, 16 square-root digit stages, fold, one stage per
// CORDIC iteration and round/clamp; the CORDIC chain sets the depth
// synchronous active-low reset clears the valid bits only
// each full stage holds when the next one is full and stalled, so bubbles close up
module rotation_matrix_to_euler #(
    parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // r11, r21, r31, r32, r33
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // angle_pitch, angle_yaw, angle_roll, zero pad
    output logic        o_m_tuser    // degenerate
);
    import rme_pkg::*;

    localparam int NPRE  = 2;
    localparam int NHEAD = NPRE + SQRT_STEPS;
    localparam int NCORD = CORDIC_STAGES + 2;
    localparam int NST   = NHEAD + NCORD;

    logic [NST-1:0] r_vld;
    logic [NST:0]   w_en;

    always_comb begin
        w_en[NST] = i_m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_s_tvalid : r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = w_en[0];
    assign o_m_tvalid = r_vld[NST-1];

    // field carry through squares and square root
    logic signed [15:0] r_p11 [0:NHEAD-1];
    logic signed [15:0] r_p21 [0:NHEAD-1];
    logic signed [15:0] r_p31 [0:NHEAD-1];
    logic signed [15:0] r_p32 [0:NHEAD-1];
    logic signed [15:0] r_p33 [0:NHEAD-1];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NHEAD; k++) begin
            if (w_en[k]) begin
                if (k == 0) begin
                    r_p11[0] <= i_s_tdata[15:0];
                    r_p21[0] <= i_s_tdata[31:16];
                    r_p31[0] <= i_s_tdata[47:32];
                    r_p32[0] <= i_s_tdata[63:48];
                    r_p33[0] <= i_s_tdata[79:64];
                end else begin
                    r_p11[k] <= r_p11[k-1];
                    r_p21[k] <= r_p21[k-1];
                    r_p31[k] <= r_p31[k-1];
                    r_p32[k] <= r_p32[k-1];
                    r_p33[k] <= r_p33[k-1];
                end
            end
        end
    end

    logic signed [31:0] w_sq11;
    logic signed [31:0] w_sq21;
    logic        [30:0] r_sq11;
    logic        [30:0] r_sq21;
    logic        [31:0] r_sum;

    assign w_sq11 = $signed(i_s_tdata[15:0]) * $signed(i_s_tdata[15:0]);
    assign w_sq21 = $signed(i_s_tdata[31:16]) * $signed(i_s_tdata[31:16]);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_sq11 <= w_sq11[30:0];
            r_sq21 <= w_sq21[30:0];
        end
        if (w_en[1]) begin
            r_sum <= {1'b0, r_sq11} + {1'b0, r_sq21};
        end
    end

    // square root, one result bit per stage
    logic [31:0] r_rem [0:SQRT_STEPS-1];
    logic [31:0] r_res [0:SQRT_STEPS-1];
    logic        r_deg [0:NST-NPRE-1];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [31:0] BIT = 32'd1 << (30 - 2 * j);
        logic [31:0] w_rin;
        logic [31:0] w_sin;
        logic [31:0] w_try;
        if (j == 0) begin : g_first
            assign w_rin = r_sum;
            assign w_sin = '0;
        end else begin : g_next
            assign w_rin = r_rem[j-1];
            assign w_sin = r_res[j-1];
        end
        assign w_try = w_sin + BIT;
        always_ff @(posedge i_clk) begin
            if (w_en[NPRE+j]) begin
                if (w_rin >= w_try) begin
                    r_rem[j] <= w_rin - w_try;
                    r_res[j] <= (w_sin >> 1) + BIT;
                end else begin
                    r_rem[j] <= w_rin;
                    r_res[j] <= w_sin >> 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST - NPRE; k++) begin
            if (w_en[NPRE+k]) begin
                r_deg[k] <= (k == 0) ? (r_sum == '0) : r_deg[k-1];
            end
        end
    end

    logic [15:0]        w_h;
    logic signed [16:0] w_py;
    logic signed [15:0] w_pitch;
    logic signed [15:0] w_yaw;
    logic signed [15:0] w_roll;

    assign w_h  = r_res[SQRT_STEPS-1][15:0];
    assign w_py = -{r_p31[NHEAD-1][15], r_p31[NHEAD-1]};

    rme_cordic #(.STAGES(CORDIC_STAGES), .LIMIT(HALF_PI_Q13)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en[NHEAD +: NCORD]),
        .i_y     (w_py),
        .i_x     ({1'b0, w_h}),
        .o_angle (w_pitch)
    );

    rme_cordic #(.STAGES(CORDIC_STAGES), .LIMIT(PI_Q13)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en[NHEAD +: NCORD]),
        .i_y     ({r_p21[NHEAD-1][15], r_p21[NHEAD-1]}),
        .i_x     ({r_p11[NHEAD-1][15], r_p11[NHEAD-1]}),
        .o_angle (w_yaw)
    );

    rme_cordic #(.STAGES(CORDIC_STAGES), .LIMIT(PI_Q13)) u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en[NHEAD +: NCORD]),
        .i_y     ({r_p32[NHEAD-1][15], r_p32[NHEAD-1]}),
        .i_x     ({r_p33[NHEAD-1][15], r_p33[NHEAD-1]}),
        .o_angle (w_roll)
    );

    assign o_m_tdata = {1'b0, w_roll, w_yaw, w_pitch[14:0]};
    assign o_m_tuser = r_deg[NST-NPRE-1];

endmodule
